// ===== rtl/tro_pkg.sv =====
`timescale 1ns / 1ps

package tro_pkg;

  // Per-stage load enables shared by the top level and the edge datapaths.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Number of triangle edges tested in parallel.
  localparam int NUM_EDGES = 3;

endpackage

// ===== rtl/tro_edge.sv =====
`timescale 1ns / 1ps

module tro_edge #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  tro_pkg::stage_en_t           en,
  input  logic signed [COORD_BITS-1:0] xa_i,
  input  logic signed [COORD_BITS-1:0] ya_i,
  input  logic signed [COORD_BITS-1:0] xb_i,
  input  logic signed [COORD_BITS-1:0] yb_i,
  input  logic signed [COORD_BITS-1:0] rect_l_i,
  input  logic signed [COORD_BITS-1:0] rect_t_i,
  input  logic signed [COORD_BITS:0]   rect_r_i,
  input  logic signed [COORD_BITS:0]   rect_b_i,
  output logic                         pass_o
);

  localparam int C = COORD_BITS;
  localparam int W = C + 1;       // differences and far rectangle sides
  localparam int D = C + 2;       // x offsets from the left vertex
  localparam int P = 2 * C + 4;   // scaled y values

  // Stage 0: order the vertices by x and derive offsets
  logic                  swap;
  logic signed [C-1:0]   xa, ya, xb, yb;
  logic signed [C-1:0]   ylo_nxt, yhi_nxt;
  logic signed [W-1:0]   dx_nxt, dy_nxt, xt, xo;
  logic signed [D-1:0]   dxt_nxt, dxo_nxt;
  logic                  up, vert_nxt, vp_nxt;

  always_comb begin
    swap    = xb_i < xa_i;
    xa      = swap ? xb_i : xa_i;
    ya      = swap ? yb_i : ya_i;
    xb      = swap ? xa_i : xb_i;
    yb      = swap ? ya_i : yb_i;
    ylo_nxt = (ya_i < yb_i) ? ya_i : yb_i;
    yhi_nxt = (ya_i < yb_i) ? yb_i : ya_i;
    dx_nxt  = W'(xb) - W'(xa);
    dy_nxt  = W'(yb) - W'(ya);
    up      = !dy_nxt[W-1] && (dy_nxt != '0);
    xt      = up ? W'(rect_l_i) : rect_r_i;
    xo      = up ? rect_r_i : W'(rect_l_i);
    dxt_nxt = D'(xt) - D'(xa);
    dxo_nxt = D'(xo) - D'(xa);
    vert_nxt = (xa_i == xb_i);
    vp_nxt   = vert_nxt && (W'(xa_i) >= W'(rect_l_i)) && (W'(xa_i) <= rect_r_i) &&
               (ylo_nxt < yhi_nxt) && (W'(yhi_nxt) >= W'(rect_t_i)) &&
               (W'(ylo_nxt) <= rect_b_i);
  end

  logic signed [W-1:0] dx_r, dy_r, bt_r;
  logic signed [C-1:0] ya_r, ylo_r, yhi_r, t_r;
  logic signed [D-1:0] dxt_r, dxo_r;
  logic                vert1_r, vp1_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      ya_r    <= ya;
      ylo_r   <= ylo_nxt;
      yhi_r   <= yhi_nxt;
      dxt_r   <= dxt_nxt;
      dxo_r   <= dxo_nxt;
      t_r     <= rect_t_i;
      bt_r    <= rect_b_i;
      vert1_r <= vert_nxt;
      vp1_r   <= vp_nxt;
    end
  end

  // Stage 1: scale the y values by the edge's x-length and dy by the x offsets
  logic signed [2*C:0]   base_nxt, los_nxt, his_nxt, tdx_nxt;
  logic signed [2*C+2:0] pt_nxt, po_nxt;
  logic signed [2*C+1:0] btdx_nxt;

  always_comb begin
    base_nxt = ya_r * dx_r;
    los_nxt  = ylo_r * dx_r;
    his_nxt  = yhi_r * dx_r;
    tdx_nxt  = t_r * dx_r;
    pt_nxt   = dy_r * dxt_r;
    po_nxt   = dy_r * dxo_r;
    btdx_nxt = bt_r * dx_r;
  end

  logic signed [2*C:0]   base_r, los_r, his_r, tdx2_r;
  logic signed [2*C+2:0] pt_r, po_r;
  logic signed [2*C+1:0] btdx2_r;
  logic                  vert2_r, vp2_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      base_r  <= base_nxt;
      los_r   <= los_nxt;
      his_r   <= his_nxt;
      tdx2_r  <= tdx_nxt;
      pt_r    <= pt_nxt;
      po_r    <= po_nxt;
      btdx2_r <= btdx_nxt;
      vert2_r <= vert1_r;
      vp2_r   <= vp1_r;
    end
  end

  // Stage 2: line's y-span across the rectangle, clipped to the edge's y-extent
  logic signed [P-1:0] tn, bn, los_p, his_p, top_nxt, bot_nxt;

  always_comb begin
    tn      = P'(base_r) + P'(pt_r);
    bn      = P'(base_r) + P'(po_r);
    los_p   = P'(los_r);
    his_p   = P'(his_r);
    top_nxt = (los_p < tn) ? tn : los_p;
    bot_nxt = (bn < his_p) ? bn : his_p;
  end

  logic signed [P-1:0] top_r, bot_r, tdx3_r, btdx3_r;
  logic                vert3_r, vp3_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      top_r   <= top_nxt;
      bot_r   <= bot_nxt;
      tdx3_r  <= P'(tdx2_r);
      btdx3_r <= P'(btdx2_r);
      vert3_r <= vert2_r;
      vp3_r   <= vp2_r;
    end
  end

  // Stage 3: vertical edges use their own test; else span must be positive and meet the rectangle's y-range
  assign pass_o = vert3_r ? vp3_r
                          : ((top_r < bot_r) && !(bot_r < tdx3_r) && !(btdx3_r < top_r));

endmodule

// ===== rtl/triangle_rect_overlap_test.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Ports                                         | Transfer when
// ----------+-----------+-----------------------------------------------+----------------------
// input     | in        | in_rect_left/top/width/height, in_valid/ready | in_valid && in_ready
// result    | out       | out_hit, out_valid/ready                      | out_valid && out_ready
// config    | in        | psel, penable, pwrite, paddr, pwdata, prdata  | psel && penable &&
//           |           | pready (tied high)                            | pwrite && pready
//
// Throughput is one rectangle per cycle while out_ready does not stall the pipe;
// a query passes the edge datapath stages (offsets, multipliers, wide
// add and clip) and then the result register before out_valid rises.
// Reset (rst_n low, synchronous) clears all valid bits and the vertex registers.
// Each stage holds while the next one is full and stalled; empty stages still
// advance, so bubbles collapse and in_ready stays high until the pipe is full.

module triangle_rect_overlap_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // query channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_rect_left,
  input  logic signed [COORD_BITS-1:0] in_rect_top,
  input  logic        [COORD_BITS-2:0] in_rect_width,
  input  logic        [COORD_BITS-2:0] in_rect_height,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic        [4:0]            paddr,
  input  logic        [31:0]           pwdata,
  output logic        [31:0]           prdata,
  output logic                         pready
);

  localparam int C = COORD_BITS;
  localparam int W = C + 1;

  typedef enum logic [2:0] {
    REG_TRI_X1 = 3'd0,
    REG_TRI_Y1 = 3'd1,
    REG_TRI_X2 = 3'd2,
    REG_TRI_Y2 = 3'd3,
    REG_TRI_X3 = 3'd4,
    REG_TRI_Y3 = 3'd5
  } reg_idx_t;

  // ---------------------------------------------------------------------
  // Vertex registers
  // ---------------------------------------------------------------------
  logic signed [C-1:0] tri_x_r [tro_pkg::NUM_EDGES];
  logic signed [C-1:0] tri_y_r [tro_pkg::NUM_EDGES];
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tro_pkg::NUM_EDGES; k++) begin
        tri_x_r[k] <= '0;
        tri_y_r[k] <= '0;
      end
    end else if (wr_en) begin
      // Keep the low coordinate bits; drop writes past the last register.
      unique case (reg_idx)
        REG_TRI_X1: tri_x_r[0] <= pwdata[C-1:0];
        REG_TRI_Y1: tri_y_r[0] <= pwdata[C-1:0];
        REG_TRI_X2: tri_x_r[1] <= pwdata[C-1:0];
        REG_TRI_Y2: tri_y_r[1] <= pwdata[C-1:0];
        REG_TRI_X3: tri_x_r[2] <= pwdata[C-1:0];
        REG_TRI_Y3: tri_y_r[2] <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended coordinates.
  always_comb begin
    unique case (reg_idx)
      REG_TRI_X1: prdata = 32'(tri_x_r[0]);
      REG_TRI_Y1: prdata = 32'(tri_y_r[0]);
      REG_TRI_X2: prdata = 32'(tri_x_r[1]);
      REG_TRI_Y2: prdata = 32'(tri_y_r[1]);
      REG_TRI_X3: prdata = 32'(tri_x_r[2]);
      REG_TRI_Y3: prdata = 32'(tri_y_r[2]);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its
  // successor loads this cycle.
  // ---------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r, out_hit_r;
  logic rdy1, rdy2, rdy3, rdy_o;
  tro_pkg::stage_en_t en;

  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_o;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign en       = '{s1: rdy1, s2: rdy2, s3: rdy3};

  // ---------------------------------------------------------------------
  // Stage 0: far rectangle sides and the strict bounding-box overlap
  // ---------------------------------------------------------------------
  logic signed [W-1:0] rect_r, rect_b;
  logic signed [C-1:0] bxl, bxr, byt, byb;
  logic signed [W-1:0] ox_lo, ox_hi, oy_lo, oy_hi;
  logic                bb_nxt;

  always_comb begin
    rect_r = W'(in_rect_left) + $signed({2'b00, in_rect_width});
    rect_b = W'(in_rect_top)  + $signed({2'b00, in_rect_height});
    bxl = tri_x_r[0];
    bxr = tri_x_r[0];
    byt = tri_y_r[0];
    byb = tri_y_r[0];
    for (int k = 1; k < tro_pkg::NUM_EDGES; k++) begin
      if (tri_x_r[k] < bxl) bxl = tri_x_r[k];
      if (tri_x_r[k] > bxr) bxr = tri_x_r[k];
      if (tri_y_r[k] < byt) byt = tri_y_r[k];
      if (tri_y_r[k] > byb) byb = tri_y_r[k];
    end
    ox_lo  = (bxl > in_rect_left) ? W'(bxl) : W'(in_rect_left);
    ox_hi  = (W'(bxr) < rect_r)   ? W'(bxr) : rect_r;
    oy_lo  = (byt > in_rect_top)  ? W'(byt) : W'(in_rect_top);
    oy_hi  = (W'(byb) < rect_b)   ? W'(byb) : rect_b;
    bb_nxt = (ox_lo < ox_hi) && (oy_lo < oy_hi);
  end

  // ---------------------------------------------------------------------
  // Edge datapaths: (v1,v2), (v2,v3), (v3,v1)
  // ---------------------------------------------------------------------
  logic [tro_pkg::NUM_EDGES-1:0] edge_pass;

  for (genvar g = 0; g < tro_pkg::NUM_EDGES; g++) begin : g_edge
    tro_edge #(
      .COORD_BITS (COORD_BITS)
    ) u_edge (
      .clk      (clk),
      .en       (en),
      .xa_i     (tri_x_r[g]),
      .ya_i     (tri_y_r[g]),
      .xb_i     (tri_x_r[(g + 1) % tro_pkg::NUM_EDGES]),
      .yb_i     (tri_y_r[(g + 1) % tro_pkg::NUM_EDGES]),
      .rect_l_i (in_rect_left),
      .rect_t_i (in_rect_top),
      .rect_r_i (rect_r),
      .rect_b_i (rect_b),
      .pass_o   (edge_pass[g])
    );
  end

  // ---------------------------------------------------------------------
  // Carry the overlap flag alongside the edge stages
  // ---------------------------------------------------------------------
  logic bb1_r, bb2_r, bb3_r;
  logic v1_nxt, v2_nxt, v3_nxt, out_valid_nxt, out_hit_nxt;

  assign v1_nxt        = rdy1 ? in_valid : v1_r;
  assign v2_nxt        = rdy2 ? v1_r     : v2_r;
  assign v3_nxt        = rdy3 ? v2_r     : v3_r;
  assign out_valid_nxt = rdy_o ? v3_r    : out_valid_r;
  // Require overlap of the bounding boxes and at least one passing edge.
  assign out_hit_nxt   = bb3_r && (|edge_pass);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) bb1_r <= bb_nxt;
    if (rdy2) bb2_r <= bb1_r;
    if (rdy3) bb3_r <= bb2_r;
    if (rdy_o) out_hit_r <= out_hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

// ===== rtl/tro_checker.sv =====
`timescale 1ns / 1ps

module tro_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit,
  input logic pready
);

  // Track items in flight: four pipeline slots at most.
  logic [2:0] cnt_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != 3'd0))
    else $error("result without a pending query");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("more queries in flight than pipeline slots");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0) |-> in_ready)
    else $error("input stalled while the pipeline is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit)))
    else $error("stalled result dropped or changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("config port inserted a wait state");

endmodule

bind triangle_rect_overlap_test tro_checker u_tro_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_hit   (out_hit),
  .pready    (pready)
);
